// ===== hw/rtl/tccw_pkg.sv =====
// Package for the text console character writer: sizes, codes, payload and control types.
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int XR_W       = $clog2(COLUMNS);
    localparam int YR_W       = $clog2(ROWS);
    localparam int XN_W       = $clog2(COLUMNS + TAB_STOP);
    localparam int YN_W       = $clog2(ROWS + 1);

    // Fixed field widths
    localparam int CHAR_W = 8;
    localparam int INDEX_W = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // Character codes and attributes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'd48;
    localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'd58;
    localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7A;
    localparam logic [ATTR_W-1:0] FIXED_ATTR  = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;

    typedef enum logic [1:0] {
        CMD_PUT        = 2'd0,
        CMD_READ       = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_SET_CURSOR = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        CNT_ZERO,
        CNT_COPY_SRC,
        CNT_LAST_ROW
    } cnt_sel_t;

    typedef struct packed {
        command_t            command;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
    } req_item_t;

    typedef struct packed {
        logic [OFF_W-1:0]    cursor_offset;
        logic [CELL_W-1:0]   cell_data;
        logic                scrolled;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic     latch;
        logic     exec;
        logic     rd_en;
        logic     rd_copy;
        logic     cnt_load;
        cnt_sel_t cnt_sel;
        logic     cnt_inc;
        logic     fill_wr;
        logic     out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        command_t command;
        logic     scroll_need;
        logic     cnt_last;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller state machine for the text console character writer.
`default_nettype none

module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_DRAIN,
        S_FILL,
        S_OUT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.cnt_sel    = CNT_ZERO;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.command == CMD_CLEAR)
                begin
                    cmd.cnt_load = 1'b1;
                    cmd.cnt_sel  = CNT_ZERO;
                    state_next   = S_FILL;
                end
                else if (status.command == CMD_PUT && status.scroll_need)
                begin
                    cmd.cnt_load = 1'b1;
                    cmd.cnt_sel  = CNT_COPY_SRC;
                    state_next   = S_COPY;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT_WAIT;
                end
            end
            S_COPY:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_copy = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.cnt_load = 1'b1;
                cmd.cnt_sel  = CNT_LAST_ROW;
                state_next   = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_last)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT_WAIT;
                    end
                end
            end
            S_OUT_WAIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold output valid until the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("result loaded over a pending result");

    // Execution always follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $past(req_valid && !req_stall))
        else $error("execute without an accepted item");

    // A scroll copy is always followed by the drain state before filling
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY && status.cnt_last) |=> (state_reg == S_DRAIN))
        else $error("copy did not drain before fill");

endmodule

`default_nettype wire

// ===== hw/rtl/tccw_datapath.sv =====
// Datapath for the text console character writer: cursor, attribute, screen memory, counters.
`default_nettype none

module tccw_datapath
    import tccw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_status_t           status,
    input  wire req_item_t         req_data,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_data,
    output rsp_item_t              rsp_data
);

    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'((ROWS - 1) * COLUMNS);

    // Screen memory
    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;

    // Cursor and attribute
    logic [XR_W-1:0]   cursor_x_reg;
    logic [XR_W-1:0]   cursor_x_next;
    logic [YR_W-1:0]   cursor_y_reg;
    logic [YR_W-1:0]   cursor_y_next;
    logic [ATTR_W-1:0] attr_reg;

    // Latched item
    command_t          cmd_code_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              idx_ok_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    // Sweep counter and copy pipeline
    logic [ADDR_W-1:0] cnt_reg;
    logic              copy_pend_reg;
    logic [ADDR_W-1:0] copy_dst_reg;
    logic              scrolled_reg;

    rsp_item_t         rsp_reg;

    logic              req_idx_ok;
    logic [ADDR_W-1:0] cur_pos;
    logic [ADDR_W-1:0] new_offset;
    logic [CELL_W-1:0] blank_cell;
    logic              is_fixed;
    logic              is_print;
    logic [XN_W-1:0]   x_ext;
    logic [XN_W-1:0]   x_a;
    logic [YN_W-1:0]   y_a;
    logic              put_scroll;
    logic              scrolled_val;
    logic [CELL_W-1:0] cell_val;

    assign req_idx_ok = (req_data.cell_index < INDEX_W'(CELL_COUNT));
    assign blank_cell = {attr_reg, CH_SPACE};
    assign cur_pos    = ADDR_W'(cursor_y_reg) * COLS_A + ADDR_W'(cursor_x_reg);
    assign is_fixed   = (char_reg >= CH_DIGIT_LO && char_reg <= CH_DIGIT_HI) ||
                        (char_reg >= CH_LOWER_LO && char_reg <= CH_LOWER_HI);
    assign is_print   = (char_reg >= CH_SPACE);
    assign x_ext      = XN_W'(cursor_x_reg);

    // Advance the cursor for a put
    always_comb
    begin
        x_a = x_ext;
        y_a = YN_W'(cursor_y_reg);
        case (char_reg)
            CH_BS:
            begin
                if (x_ext != '0)
                begin
                    x_a = x_ext - XN_W'(1);
                end
            end
            CH_TAB:
            begin
                x_a = x_ext - XN_W'(x_ext % TAB_STOP) + XN_W'(TAB_STOP);
            end
            CH_CR:
            begin
                x_a = '0;
            end
            CH_LF:
            begin
                x_a = '0;
                y_a = YN_W'(cursor_y_reg) + YN_W'(1);
            end
            default:
            begin
                if (is_print)
                begin
                    x_a = x_ext + XN_W'(1);
                end
            end
        endcase
        if (x_a >= XN_W'(COLUMNS))
        begin
            x_a = '0;
            y_a = y_a + YN_W'(1);
        end
    end

    assign put_scroll = (y_a >= YN_W'(ROWS));

    // Next cursor for the executed command
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.exec)
        begin
            case (cmd_code_reg)
                CMD_PUT:
                begin
                    cursor_x_next = XR_W'(x_a);
                    cursor_y_next = put_scroll ? YR_W'(ROWS - 1) : YR_W'(y_a);
                end
                CMD_CLEAR:
                begin
                    cursor_x_next = '0;
                    cursor_y_next = '0;
                end
                CMD_SET_CURSOR:
                begin
                    cursor_x_next = (col_reg >= COL_W'(COLUMNS - 1)) ?
                                    XR_W'(COLUMNS - 1) : XR_W'(col_reg);
                    cursor_y_next = (row_reg >= ROW_W'(ROWS - 1)) ?
                                    YR_W'(ROWS - 1) : YR_W'(row_reg);
                end
                default:
                begin
                    cursor_x_next = cursor_x_reg;
                    cursor_y_next = cursor_y_reg;
                end
            endcase
        end
    end

    assign new_offset = ADDR_W'(cursor_y_next) * COLS_A + ADDR_W'(cursor_x_next);

    // Select the memory write: pending copy, blank fill, then character cell
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_pos;
        wr_data = {FIXED_ATTR, char_reg};
        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_dst_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.fill_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = blank_cell;
        end
        else if (cmd.exec && cmd_code_reg == CMD_PUT && is_print)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_pos;
            wr_data = {(is_fixed ? FIXED_ATTR : attr_reg), char_reg};
        end
    end

    // Read from the copy source during a scroll, else from the requested cell
    assign rd_addr = cmd.rd_copy ? cnt_reg :
                     (req_idx_ok ? ADDR_W'(req_data.cell_index) : '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            attr_reg      <= ATTR_RESET;
            copy_pend_reg <= 1'b0;
            scrolled_reg  <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            copy_pend_reg <= cmd.rd_copy;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                scrolled_reg <= (cmd_code_reg == CMD_PUT) && put_scroll;
            end
        end
    end

    assign scrolled_val = cmd.exec ? ((cmd_code_reg == CMD_PUT) && put_scroll) :
                          scrolled_reg;
    assign cell_val     = (cmd_code_reg == CMD_READ && idx_ok_reg) ? rd_data_reg : '0;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_code_reg <= req_data.command;
            char_reg     <= req_data.char_code;
            idx_ok_reg   <= req_idx_ok;
            col_reg      <= req_data.cursor_col;
            row_reg      <= req_data.cursor_row;
        end
        if (cmd.cnt_load)
        begin
            case (cmd.cnt_sel)
                CNT_ZERO:     cnt_reg <= '0;
                CNT_COPY_SRC: cnt_reg <= COLS_A;
                CNT_LAST_ROW: cnt_reg <= LAST_ROW_A;
                default:      cnt_reg <= '0;
            endcase
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
        if (cmd.rd_copy)
        begin
            copy_dst_reg <= cnt_reg - COLS_A;
        end
        if (cmd.out_load)
        begin
            rsp_reg.cursor_offset <= OFF_W'(new_offset);
            rsp_reg.cell_data     <= cell_val;
            rsp_reg.scrolled      <= scrolled_val;
        end
    end

    assign rsp_data           = rsp_reg;
    assign status.command     = cmd_code_reg;
    assign status.scroll_need = put_scroll;
    assign status.cnt_last    = (cnt_reg == LAST_CELL);

    // Fill never contends with a pending copy write
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_wr |-> !copy_pend_reg)
        else $error("fill write collides with copy write");

    // The cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_x_reg < XR_W'(COLUMNS)) && (cursor_y_reg < YR_W'(ROWS)))
        else $error("cursor off screen");

    // A scroll leaves the cursor on the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd_code_reg == CMD_PUT && put_scroll) |=>
            (cursor_y_reg == YR_W'(ROWS - 1)))
        else $error("scroll left cursor off the bottom row");

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_char_writer_unit.sv =====
// Put, read and set-cursor go from idle through execute to a registered result, waiting
// in the output-wait state while an earlier result is stalled. A put that scrolls adds a row
// copy, the drain state and a bottom-row fill; a clear adds a blank fill of every cell. The
// single memory write port sets both sweeps. Items are taken only in idle, also while a
// result waits. Reset: cursor at 0,0, attribute 0x0F, no result pending; screen memory is
// undefined until cleared or written, with no clearing pass after reset.
`default_nettype none

module text_console_char_writer_unit
    import tccw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_item_t         req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_item_t              rsp_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ATTR_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Take attribute writes at any time
    assign cfg_ready = 1'b1;

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tccw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req_data (req_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the text console character writer.
module tb_top
    import tccw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_item_t         req_data = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_item_t         rsp_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;

    // Shadow console state
    logic [CELL_W-1:0] screen_img [CELL_COUNT];
    int unsigned       cur_x;
    int unsigned       cur_y;
    logic [ATTR_W-1:0] text_attr;

    req_item_t commands_to_send [$];
    rsp_item_t console_replies_due [$];
    int        fail_count;
    int        send_gap;
    int        hold_left;
    int        idle_cycles;
    bit        calm_mode;

    text_console_char_writer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one command to the shadow console and return its result
    function automatic rsp_item_t console_apply(req_item_t rq);
        rsp_item_t         rs;
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] blank;
        logic [CHAR_W-1:0] ch;
        rs = '0;
        ch = rq.char_code;
        blank = {text_attr, CH_SPACE};
        case (rq.command)
            CMD_PUT:
            begin
                if (ch == CH_BS)
                begin
                    if (cur_x != 0)
                        cur_x = cur_x - 1;
                end
                else if (ch == CH_TAB)
                    cur_x = cur_x + TAB_STOP - (cur_x % TAB_STOP);
                else if (ch == CH_CR)
                    cur_x = 0;
                else if (ch == CH_LF)
                begin
                    cur_x = 0;
                    cur_y = cur_y + 1;
                end
                else if (ch >= CH_SPACE)
                begin
                    // digits, colon and lowercase keep the fixed attribute
                    if ((ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) ||
                        (ch >= CH_LOWER_LO && ch <= CH_LOWER_HI))
                        attr = FIXED_ATTR;
                    else
                        attr = text_attr;
                    screen_img[cur_y * COLUMNS + cur_x] = {attr, ch};
                    cur_x = cur_x + 1;
                end
                // wrap at the right margin
                if (cur_x >= COLUMNS)
                begin
                    cur_x = 0;
                    cur_y = cur_y + 1;
                end
                // scroll past the bottom row
                if (cur_y >= ROWS)
                begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_img[i] = screen_img[i + COLUMNS];
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_img[i] = blank;
                    cur_y = ROWS - 1;
                    rs.scrolled = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (rq.cell_index < CELL_COUNT)
                    rs.cell_data = screen_img[rq.cell_index];
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_img[i] = blank;
                cur_x = 0;
                cur_y = 0;
            end
            default:
            begin
                cur_x = (rq.cursor_col >= COLUMNS) ? COLUMNS - 1 : rq.cursor_col;
                cur_y = (rq.cursor_row >= ROWS) ? ROWS - 1 : rq.cursor_row;
            end
        endcase
        rs.cursor_offset = OFF_W'(cur_y * COLUMNS + cur_x);
        return rs;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build a command with random filler in the fields it does not use
    function automatic req_item_t make_cmd(command_t c, int unsigned a, int unsigned b);
        req_item_t it;
        it.command    = c;
        it.char_code  = CHAR_W'($urandom);
        it.cell_index = INDEX_W'($urandom);
        it.cursor_col = COL_W'($urandom);
        it.cursor_row = ROW_W'($urandom);
        case (c)
            CMD_PUT:        it.char_code = CHAR_W'(a);
            CMD_READ:       it.cell_index = INDEX_W'(a);
            CMD_SET_CURSOR:
            begin
                it.cursor_col = COL_W'(a);
                it.cursor_row = ROW_W'(b);
            end
            default:        ;
        endcase
        return it;
    endfunction

    // Random command, weighted toward puts and cursor moves near the bottom
    function automatic req_item_t rand_cmd();
        int unsigned r;
        int unsigned k;
        int unsigned ch;
        int unsigned col;
        int unsigned row;
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
                ch = $urandom_range(8'h20, 8'h7E);
            else if (k < 55)
                ch = $urandom_range(8'h80, 8'hFF);
            else if (k < 70)
                ch = ($urandom_range(0, 1) == 0) ? $urandom_range(8'h2F, 8'h3B)
                                                 : $urandom_range(8'h60, 8'h7B);
            else if (k < 90)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = CH_BS;
                    1:       ch = CH_TAB;
                    2:       ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            else
                ch = $urandom_range(0, 8'h1F);
            return make_cmd(CMD_PUT, ch, 0);
        end
        if (r < 78)
        begin
            if ($urandom_range(0, 99) < 85)
                return make_cmd(CMD_READ, $urandom_range(0, CELL_COUNT - 1), 0);
            return make_cmd(CMD_READ, $urandom_range(CELL_COUNT, 2047), 0);
        end
        if (r < 96)
        begin
            col = ($urandom_range(0, 99) < 70) ? $urandom_range(0, COLUMNS - 1)
                                               : $urandom_range(COLUMNS, 127);
            k = $urandom_range(0, 99);
            if (k < 50)
                row = $urandom_range(ROWS - 5, ROWS - 1);
            else if (k < 80)
                row = $urandom_range(0, ROWS - 1);
            else
                row = $urandom_range(ROWS, 31);
            return make_cmd(CMD_SET_CURSOR, col, row);
        end
        return make_cmd(CMD_CLEAR, 0, 0);
    endfunction

    // Request driver: hold a stalled transfer, insert gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        logic      next_valid;
        req_item_t next_item;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_gap  <= 0;
        end
        else
        begin
            next_valid = req_valid;
            next_item  = req_data;
            if (req_valid && !req_stall)
            begin
                console_replies_due.push_back(console_apply(req_data));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (commands_to_send.size() != 0)
                begin
                    next_item  = commands_to_send.pop_front();
                    next_valid = 1'b1;
                    send_gap   <= pick_gap();
                end
            end
            req_valid <= next_valid;
            req_data  <= next_item;
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_item_t want;
        int        g;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (console_replies_due.size() == 0)
                begin
                    $error("result with nothing predicted: cursor_offset %0d",
                           rsp_data.cursor_offset);
                    fail_count++;
                end
                else
                begin
                    want = console_replies_due.pop_front();
                    if (rsp_data.cursor_offset !== want.cursor_offset)
                    begin
                        $error("cursor_offset: expected %0d, got %0d",
                               want.cursor_offset, rsp_data.cursor_offset);
                        fail_count++;
                    end
                    if (rsp_data.cell_data !== want.cell_data)
                    begin
                        $error("cell_data: expected %h, got %h",
                               want.cell_data, rsp_data.cell_data);
                        fail_count++;
                    end
                    if (rsp_data.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0b, got %0b",
                               want.scrolled, rsp_data.scrolled);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                g = pick_gap();
                rsp_stall <= (g != 0);
                if (g != 0)
                    hold_left <= g - 1;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Wait until every command is sent and every result is back, then settle
    task automatic drain();
        while (commands_to_send.size() != 0 || req_valid || console_replies_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the attribute register over its own channel
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        text_attr = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [ATTR_W-1:0] attr_plan [5];
        for (int i = 0; i < CELL_COUNT; i++)
            screen_img[i] = '0;
        cur_x       = 0;
        cur_y       = 0;
        text_attr   = ATTR_RESET;
        fail_count  = 0;
        calm_mode   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: write a cell before any clear, then corner cases
        commands_to_send.push_back(make_cmd(CMD_PUT, 8'h61, 0));
        commands_to_send.push_back(make_cmd(CMD_READ, 0, 0));
        commands_to_send.push_back(make_cmd(CMD_READ, 2047, 0));
        commands_to_send.push_back(make_cmd(CMD_CLEAR, 0, 0));
        commands_to_send.push_back(make_cmd(CMD_READ, CELL_COUNT - 1, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, 8'h00, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, 8'hFF, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_DIGIT_LO, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_DIGIT_HI, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_LOWER_HI, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_DIGIT_LO - 1, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_LOWER_HI + 1, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_SPACE, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_BS, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_TAB, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_CR, 0));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_LF, 0));
        // backspace at column zero stays put
        commands_to_send.push_back(make_cmd(CMD_SET_CURSOR, 0, 3));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_BS, 0));
        // saturated cursor, then wrap into a scroll
        commands_to_send.push_back(make_cmd(CMD_SET_CURSOR, 127, 31));
        commands_to_send.push_back(make_cmd(CMD_PUT, 8'h78, 0));
        // line feed on the bottom row scrolls
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_LF, 0));
        // tab past the right margin on the bottom row scrolls
        commands_to_send.push_back(make_cmd(CMD_SET_CURSOR, COLUMNS - 4, ROWS - 1));
        commands_to_send.push_back(make_cmd(CMD_PUT, CH_TAB, 0));
        commands_to_send.push_back(make_cmd(CMD_READ, CELL_COUNT - COLUMNS, 0));
        drain();

        // Random phases, one attribute setting each
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = ATTR_W'($urandom_range(1, 254));
        attr_plan[3] = ATTR_W'($urandom_range(1, 254));
        attr_plan[4] = ATTR_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_attribute(attr_plan[p]);
            calm_mode = (p == 2);
            repeat (105) commands_to_send.push_back(rand_cmd());
            drain();
        end

        repeat (40) @(posedge clk);
        if (console_replies_due.size() != 0)
        begin
            $error("%0d results never arrived", console_replies_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
